>>> design/rgbled_pkg.sv
`timescale 1ns / 1ps

package rgbled_pkg;

  localparam int unsigned ModeW  = 2;
  localparam int unsigned ColorW = 32;
  localparam int unsigned RgbW   = 24;
  localparam int unsigned TimeW  = 20;
  localparam int unsigned StepW  = 10;
  localparam int unsigned LevelW = 8;
  localparam int unsigned ChanW  = 2;
  localparam int unsigned StartW = 5;
  localparam int unsigned PosW   = 3;
  localparam int unsigned RampPtW = 7;

  localparam int unsigned RampLenDefault = 8;
  localparam int unsigned QueueDepth     = 2;

  localparam logic [StepW-1:0] RampStepReset = 10'd50;

  localparam logic [ModeW-1:0] MODE_BATTERY   = 2'd0;
  localparam logic [ModeW-1:0] MODE_NOTIFY    = 2'd1;
  localparam logic [ModeW-1:0] MODE_ATTENTION = 2'd2;
  localparam logic [ModeW-1:0] MODE_NONE      = 2'd3;

  localparam logic [ChanW-1:0] CH_RED  = 2'd0;
  localparam logic [ChanW-1:0] CH_BLUE = 2'd2;

  localparam logic [7:0] AlphaFull = 8'hFF;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_UPD,
    FS_SEL,
    FS_PUSH
  } front_state_t;

  // One chosen request, ready to be expanded into result items.
  typedef struct packed {
    logic                    blink;
    logic                    stop;
    logic [2:0][LevelW-1:0]  ch;
    logic [TimeW-1:0]        off_ms;
    logic [TimeW-1:0]        phi_ms;
    logic [StepW-1:0]        step_ms;
  } job_t;

  // Exact x/255 for any x below 65280.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = 17'(x) + 17'(x[15:8]) + 17'd1;
    return sum[15:8];
  endfunction

  function automatic logic [RampPtW-1:0] base_ramp(input logic [2:0] k);
    logic [RampPtW-1:0] v;
    case (k)
      3'd0:    v = 7'd0;
      3'd1:    v = 7'd12;
      3'd2:    v = 7'd25;
      3'd3:    v = 7'd37;
      3'd4:    v = 7'd50;
      3'd5:    v = 7'd72;
      3'd6:    v = 7'd85;
      3'd7:    v = 7'd100;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

endpackage

>>> design/rgbled_front.sv
`timescale 1ns / 1ps

module rgbled_front #(
  parameter int unsigned RAMP_LEN = rgbled_pkg::RampLenDefault
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rgbled_pkg::ModeW-1:0]   in_mode,
  input  logic [rgbled_pkg::ColorW-1:0]  in_color,
  input  logic                           in_flash_timed,
  input  logic [rgbled_pkg::TimeW-1:0]   in_on_ms,
  input  logic [rgbled_pkg::TimeW-1:0]   in_off_ms,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rgbled_pkg::StepW-1:0]   cfg_ramp_step_ms,
  output logic                           push_valid,
  input  logic                           push_ready,
  output rgbled_pkg::job_t               push_job
);
  import rgbled_pkg::*;

  // Constant divisor 2*RAMP_LEN, done as a multiply by a rounded-up reciprocal.
  localparam int unsigned Div   = 2 * RAMP_LEN;
  localparam int unsigned DivSh = $clog2(Div);
  localparam int unsigned RecSh = TimeW + DivSh;
  localparam longint unsigned RecVal = ((64'd1 << RecSh) + Div - 1) / Div;
  localparam int unsigned RecW  = RecSh - DivSh + 2;
  localparam int unsigned ProdW = TimeW + RecW;
  localparam int unsigned SpanW = StepW + DivSh + 1;

  front_state_t state_r, state_nxt;

  logic [StepW-1:0]  ramp_step_r;
  logic [ModeW-1:0]  mode_r;
  logic [ColorW-1:0] color_r;
  logic              timed_r;
  logic [TimeW-1:0]  on_in_r;
  logic [TimeW-1:0]  off_in_r;

  logic [RgbW-1:0]   slot_rgb_r   [3];
  logic              slot_timed_r [3];
  logic [TimeW-1:0]  slot_on_r    [3];
  logic [TimeW-1:0]  slot_off_r   [3];

  logic [2:0][LevelW-1:0] ch_r;
  logic [TimeW-1:0]  on_r;
  logic [TimeW-1:0]  off_r;
  logic [SpanW-1:0]  span_r;
  logic [TimeW-1:0]  quo_r;

  logic [RgbW-1:0]   rgb_new;
  logic [7:0]        alpha;
  logic              do_scale;
  logic [ModeW-1:0]  sel;
  logic [TimeW-1:0]  on_sel;
  logic [TimeW-1:0]  off_sel;
  logic [ProdW-1:0]  quo_prod;
  logic              on_short;
  logic              blink;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == FS_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FS_IDLE;
      ramp_step_r <= RampStepReset;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        ramp_step_r <= cfg_ramp_step_ms;
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    push_valid = 1'b0;
    case (state_r)
      FS_IDLE: begin
        if (in_valid && in_mode != MODE_NONE) begin
          state_nxt = FS_UPD;
        end
      end
      FS_UPD:  state_nxt = FS_SEL;
      FS_SEL:  state_nxt = FS_PUSH;
      FS_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_nxt = FS_IDLE;
        end
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  // Notification brightness scaling.
  assign alpha    = color_r[ColorW-1 -: 8];
  assign do_scale = (mode_r == MODE_NOTIFY) && (alpha != 8'd0) && (alpha != AlphaFull);

  always_comb begin
    rgb_new = color_r[RgbW-1:0];
    if (do_scale) begin
      rgb_new[23:16] = div255(16'(color_r[23:16]) * 16'(alpha));
      rgb_new[15:8]  = div255(16'(color_r[15:8]) * 16'(alpha));
      rgb_new[7:0]   = div255(16'(color_r[7:0]) * 16'(alpha));
    end
  end

  // Priority: attention, then notification, then battery.
  always_comb begin
    if (slot_rgb_r[MODE_ATTENTION] != '0) begin
      sel = MODE_ATTENTION;
    end else if (slot_rgb_r[MODE_NOTIFY] != '0) begin
      sel = MODE_NOTIFY;
    end else begin
      sel = MODE_BATTERY;
    end
  end

  assign on_sel   = slot_timed_r[sel] ? slot_on_r[sel]  : '0;
  assign off_sel  = slot_timed_r[sel] ? slot_off_r[sel] : '0;
  assign quo_prod = ProdW'(on_sel) * ProdW'(RecVal);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r   <= in_mode;
      color_r  <= in_color;
      timed_r  <= in_flash_timed;
      on_in_r  <= in_on_ms;
      off_in_r <= in_off_ms;
    end
    if (state_r == FS_SEL) begin
      ch_r[0] <= slot_rgb_r[sel][23:16];
      ch_r[1] <= slot_rgb_r[sel][15:8];
      ch_r[2] <= slot_rgb_r[sel][7:0];
      on_r    <= on_sel;
      off_r   <= off_sel;
      span_r  <= SpanW'(ramp_step_r) * SpanW'(Div);
      quo_r   <= TimeW'(quo_prod >> RecSh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        slot_rgb_r[k]   <= '0;
        slot_timed_r[k] <= 1'b0;
        slot_on_r[k]    <= '0;
        slot_off_r[k]   <= '0;
      end
    end else if (state_r == FS_UPD) begin
      slot_rgb_r[mode_r]   <= rgb_new;
      slot_timed_r[mode_r] <= timed_r;
      slot_on_r[mode_r]    <= on_in_r;
      slot_off_r[mode_r]   <= off_in_r;
    end
  end

  assign on_short = (TimeW'(0) + 32'(span_r)) > 32'(on_r);
  assign blink    = (on_r != '0) && (off_r != '0);

  always_comb begin
    push_job        = '0;
    push_job.blink  = blink;
    push_job.ch     = ch_r;
    push_job.stop   = !blink && (ch_r == '0);
    if (blink) begin
      push_job.off_ms  = off_r;
      push_job.step_ms = on_short ? StepW'(quo_r) : ramp_step_r;
      push_job.phi_ms  = on_short ? '0 : TimeW'(32'(on_r) - 32'(span_r));
    end
  end

endmodule

>>> design/rgbled_queue.sv
`timescale 1ns / 1ps

module rgbled_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  rgbled_pkg::job_t wr_job,
  output logic             rd_valid,
  input  logic             rd_ready,
  output rgbled_pkg::job_t rd_job
);
  import rgbled_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            mem_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_wr;
  logic            do_rd;

  assign wr_ready = (count_r != CntW'(QueueDepth));
  assign rd_valid = (count_r != '0);
  assign rd_job   = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

>>> design/rgbled_back.sv
`timescale 1ns / 1ps

module rgbled_back #(
  parameter int unsigned RAMP_LEN = rgbled_pkg::RampLenDefault
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           pop_valid,
  output logic                           pop_ready,
  input  rgbled_pkg::job_t               pop_job,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rgbled_pkg::ChanW-1:0]   out_channel,
  output logic                           out_blink,
  output logic [rgbled_pkg::StartW-1:0]  out_lut_start,
  output logic [rgbled_pkg::PosW-1:0]    out_lut_pos,
  output logic [rgbled_pkg::LevelW-1:0]  out_level,
  output logic [rgbled_pkg::TimeW-1:0]   out_pause_lo_ms,
  output logic [rgbled_pkg::TimeW-1:0]   out_pause_hi_ms,
  output logic [rgbled_pkg::StepW-1:0]   out_step_ms,
  output logic                           out_stop_blink,
  output logic                           out_last
);
  import rgbled_pkg::*;

  localparam int unsigned IdxW = $clog2(RAMP_LEN);

  logic [RampPtW-1:0] ramp_pt [RAMP_LEN];

  for (genvar g = 0; g < RAMP_LEN; g++) begin : g_ramp
    localparam int unsigned BaseIdx = (g * 7) / (RAMP_LEN - 1);
    assign ramp_pt[g] = base_ramp(3'(BaseIdx));
  end

  job_t            job_r;
  logic            job_valid_r;
  logic [ChanW-1:0] chan_r;
  logic [IdxW-1:0] pos_r;
  logic            out_valid_r;

  logic [LevelW-1:0] ch_sel;
  logic [15:0]       duty_prod;
  logic              emit;
  logic              last_now;
  logic [6:0]        start_full;

  assign pop_ready = !job_valid_r;
  assign out_valid = out_valid_r;
  assign emit      = job_valid_r && (!out_valid_r || out_ready);

  assign ch_sel     = job_r.ch[chan_r];
  assign duty_prod  = 16'(ramp_pt[pos_r]) * 16'(ch_sel);
  assign last_now   = (chan_r == CH_BLUE) &&
                      (!job_r.blink || pos_r == IdxW'(RAMP_LEN - 1));
  assign start_full = 7'(chan_r) * 7'(RAMP_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      chan_r      <= CH_RED;
      pos_r       <= '0;
    end else begin
      if (out_valid_r && out_ready && !emit) begin
        out_valid_r <= 1'b0;
      end
      if (!job_valid_r && pop_valid) begin
        job_valid_r <= 1'b1;
        chan_r      <= CH_RED;
        pos_r       <= '0;
      end else if (emit) begin
        out_valid_r <= 1'b1;
        if (last_now) begin
          job_valid_r <= 1'b0;
        end else if (job_r.blink && pos_r != IdxW'(RAMP_LEN - 1)) begin
          pos_r <= pos_r + 1'b1;
        end else begin
          pos_r  <= '0;
          chan_r <= chan_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!job_valid_r && pop_valid) begin
      job_r <= pop_job;
    end
    if (emit) begin
      out_channel     <= chan_r;
      out_blink       <= job_r.blink;
      out_lut_start   <= job_r.blink ? start_full[StartW-1:0] : '0;
      out_lut_pos     <= job_r.blink ? PosW'(pos_r) : '0;
      out_level       <= job_r.blink ? div255(duty_prod) : ch_sel;
      out_pause_lo_ms <= job_r.off_ms;
      out_pause_hi_ms <= job_r.phi_ms;
      out_step_ms     <= job_r.step_ms;
      out_stop_blink  <= job_r.stop;
      out_last        <= last_now;
    end
  end

endmodule

>>> design/rgb_led_priority_blink_setup_core.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Carries
// in_      input      in_valid / in_ready   one light request update
// out_     output     out_valid / out_ready one LED channel setting
// cfg_     input      cfg_valid / cfg_ready default ramp step duration in ms
//
// An update passes the front end as capture, slot write, selection with the
// step arithmetic and hand-off to the queue; an update with mode three is
// accepted and dropped. The back end loads a request and then issues one
// result per cycle while out_ready is high: 3*RAMP_LEN results for a blinking
// request, three for a steady one, so its output register paces the block.
// Reset is synchronous and active low; it clears all three slots and sets the
// step register to 50. Either side may stall: the two-entry queue lets the front
// end take further updates while the back end waits on out_ready.

module rgb_led_priority_blink_setup_core #(
  parameter int unsigned RAMP_LEN = rgbled_pkg::RampLenDefault
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rgbled_pkg::ModeW-1:0]   in_mode,
  input  logic [rgbled_pkg::ColorW-1:0]  in_color,
  input  logic                           in_flash_timed,
  input  logic [rgbled_pkg::TimeW-1:0]   in_on_ms,
  input  logic [rgbled_pkg::TimeW-1:0]   in_off_ms,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rgbled_pkg::StepW-1:0]   cfg_ramp_step_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rgbled_pkg::ChanW-1:0]   out_channel,
  output logic                           out_blink,
  output logic [rgbled_pkg::StartW-1:0]  out_lut_start,
  output logic [rgbled_pkg::PosW-1:0]    out_lut_pos,
  output logic [rgbled_pkg::LevelW-1:0]  out_level,
  output logic [rgbled_pkg::TimeW-1:0]   out_pause_lo_ms,
  output logic [rgbled_pkg::TimeW-1:0]   out_pause_hi_ms,
  output logic [rgbled_pkg::StepW-1:0]   out_step_ms,
  output logic                           out_stop_blink,
  output logic                           out_last
);
  import rgbled_pkg::*;

  // The front end holds the three request slots and the step register. For each
  // update of mode zero to two it rewrites one slot, picks the winning request,
  // works out the blink timing, then hands it over as a single request record.
  logic push_valid;
  logic push_ready;
  job_t push_job;

  // The back end expands each record into its per-channel results.
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;

  rgbled_front #(
    .RAMP_LEN (RAMP_LEN)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_color         (in_color),
    .in_flash_timed   (in_flash_timed),
    .in_on_ms         (in_on_ms),
    .in_off_ms        (in_off_ms),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_ramp_step_ms (cfg_ramp_step_ms),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_job         (push_job)
  );

  rgbled_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_job   (push_job),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_job   (pop_job)
  );

  rgbled_back #(
    .RAMP_LEN (RAMP_LEN)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_job         (pop_job),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel     (out_channel),
    .out_blink       (out_blink),
    .out_lut_start   (out_lut_start),
    .out_lut_pos     (out_lut_pos),
    .out_level       (out_level),
    .out_pause_lo_ms (out_pause_lo_ms),
    .out_pause_hi_ms (out_pause_hi_ms),
    .out_step_ms     (out_step_ms),
    .out_stop_blink  (out_stop_blink),
    .out_last        (out_last)
  );

endmodule
